>>> src/ltok_pkg.sv
// ----------------------------------------------------------------------------
// ltok_pkg
// Shared types, codes and character-class helpers for the script tokenizer.
// ----------------------------------------------------------------------------
package ltok_pkg;

   // result event codes
   localparam logic [2:0] EV_TOKEN    = 3'd0;
   localparam logic [2:0] EV_END      = 3'd1;
   localparam logic [2:0] EV_OPEN_QT  = 3'd2;
   localparam logic [2:0] EV_OPEN_CMT = 3'd3;
   localparam logic [2:0] EV_NONASCII = 3'd4;

   // token kinds
   localparam logic [1:0] KIND_WORD   = 2'd0;
   localparam logic [1:0] KIND_QUOTED = 2'd1;
   localparam logic [1:0] KIND_OPER   = 2'd2;
   localparam logic [1:0] KIND_SINGLE = 2'd3;

   // mode codes
   localparam logic [1:0] MODE_EXPR    = 2'd0;
   localparam logic [1:0] MODE_SECTION = 2'd2;

   localparam int LINE_OUT_W = 24;
   localparam int DISCARD_LEN = 9;

   // scan phase of the datapath
   typedef enum logic [3:0] {
      PH_BETWEEN    = 4'd0,
      PH_START      = 4'd1,
      PH_WORD_FIRST = 4'd2,
      PH_WORD       = 4'd3,
      PH_QUOTE      = 4'd4,
      PH_LINE_CMT   = 4'd5,
      PH_BLOCK      = 4'd6,
      PH_BLOCK_STAR = 4'd7,
      PH_EMIT       = 4'd8
   } phase_type;

   // commands from the controller
   typedef struct packed {
      logic load;
      logic step;
      logic err;
      logic eot;
   } cmd_type;

   // status back to the controller
   typedef struct packed {
      logic halt;
      logic out_free;
      logic end_seen;
   } status_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0b ||
             b == 8'h0c || b == 8'h0d;
   endfunction

   // word character class for the latched mode
   function automatic logic in_class(input logic [7:0] b, input logic [1:0] m);
      logic plain;
      plain = b == "_" || b == "." || b == "$" || b == "/" || b == "\\" ||
              b == "~" || b == "=" || b == "+" || b == "[" || b == "]" ||
              b == "*" || b == "?" || b == "-" || b == "!" || b == "^" ||
              (b == ":" && m != MODE_SECTION);
      if (is_alnum(b)) return 1'b1;
      if (m == MODE_EXPR) return b == "_" || b == "." || b == "$";
      return plain;
   endfunction

   // bytes that may open a longer operator
   function automatic logic in_wait_set(input logic [7:0] b);
      return b == "/" || b == "<" || b == ">" || b == "+" || b == "-" || b == "*" ||
             b == "!" || b == "&" || b == "^" || b == "|" || b == "=";
   endfunction

   function automatic logic in_assign_ops(input logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "!" ||
             b == "&" || b == "^" || b == "|";
   endfunction

   function automatic logic [7:0] discard_char(input logic [3:0] k);
      logic [7:0] c;
      case (k)
         4'd1:    c = "D";
         4'd2:    c = "I";
         4'd3:    c = "S";
         4'd4:    c = "C";
         4'd5:    c = "A";
         4'd6:    c = "R";
         4'd7:    c = "D";
         default: c = "/";
      endcase
      return c;
   endfunction

endpackage

>>> src/ltok_ctrl.sv
// ----------------------------------------------------------------------------
// ltok_ctrl
// Sequencer: takes a byte, runs scan steps until the datapath halts, then
// closes the script on end of text.
// ----------------------------------------------------------------------------
module ltok_ctrl
   import ltok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_ERR  = 4'b0100,
      ST_EOT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.halt) begin
               state_in = status.end_seen ? ST_ERR : ST_IDLE;
            end else if (status.out_free) begin
               cmd.step = 1'b1;
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.err  = 1'b1;
               state_in = ST_EOT;
            end
         end
         ST_EOT: begin
            if (status.out_free) begin
               cmd.eot  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands are mutually exclusive
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.err, cmd.eot}))
      else $error("more than one command");

   // a step is never issued on a halted datapath
   a_no_step_halt: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !status.halt)
      else $error("step while halted");

   // closing always follows the error slot
   a_err_then_eot: assert property (@(posedge clock) disable iff (reset)
      cmd.err |=> (state_ff == ST_EOT))
      else $error("error slot not followed by end");

endmodule

>>> src/ltok_dp.sv
// ----------------------------------------------------------------------------
// ltok_dp
// Datapath: lookahead shift buffer, scan phase, line counter and the
// registered result slot. One scan step per command.
// ----------------------------------------------------------------------------
module ltok_dp
   import ltok_pkg::*;
#(
   parameter int LOOKAHEAD_DEPTH = 9,
   parameter int LINE_BITS       = 24
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [7:0]  req_text_byte,
   input  logic [1:0]  req_mode,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_token_byte,
   output logic        rsp_token_first,
   output logic        rsp_token_last,
   output logic [1:0]  rsp_token_kind,
   output logic [LINE_OUT_W-1:0] rsp_line_number
);

   localparam int CNT_W = $clog2(LOOKAHEAD_DEPTH + 1);
   localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

   logic [7:0]       buf_ff [LOOKAHEAD_DEPTH];
   logic [7:0]       buf_in [LOOKAHEAD_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   phase_type        phase_ff, phase_in;
   logic [1:0]       tmode_ff, tmode_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic             note_ff, note_in;
   logic [3:0]       tok_left_ff, tok_left_in;
   logic             tok_first_ff, tok_first_in;
   logic [1:0]       tok_kind_ff, tok_kind_in;
   logic             end_ff, end_in;
   logic [1:0]       mode_ff, mode_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       ev_ff, ev_in;
   logic [7:0]       byte_ff, byte_in;
   logic             first_ff, first_in;
   logic             last_ff, last_in;
   logic [1:0]       kind_ff, kind_in;
   logic [LINE_BITS-1:0] rline_ff, rline_in;
   logic [LINE_BITS+LINE_OUT_W-1:0] line_ext;

   // one scan step
   logic       s_emit, s_wait, s_inc;
   logic [2:0] s_ev;
   logic [7:0] s_byte;
   logic       s_first, s_last;
   logic [1:0] s_kind;
   logic [1:0] s_drop;
   phase_type  s_phase;
   logic [1:0] s_tmode;
   logic       s_note;
   logic [3:0] s_tl;
   logic       s_tf;
   logic [1:0] s_tk;

   logic [7:0] c0, c1, c2;
   logic       have1, have2, is_word_c0, disc_ok, shl_pair;

   assign c0 = buf_ff[0];
   assign c1 = buf_ff[1];
   assign c2 = buf_ff[2];
   assign have1 = count_ff >= CNT_W'(2);
   assign have2 = count_ff >= CNT_W'(3);
   assign is_word_c0 = in_class(c0, tmode_ff);
   assign shl_pair = (c0 == "<" || c0 == ">") && have1 && c1 == c0;

   // prefix match against /DISCARD/
   always_comb begin
      disc_ok = 1'b1;
      for (int k = 1; k < DISCARD_LEN; k++) begin
         if (CNT_W'(k) < count_ff && buf_ff[k] != discard_char(4'(k))) disc_ok = 1'b0;
      end
   end

   always_comb begin
      s_emit  = 1'b0;
      s_wait  = 1'b0;
      s_inc   = 1'b0;
      s_ev    = EV_TOKEN;
      s_byte  = 8'd0;
      s_first = 1'b0;
      s_last  = 1'b0;
      s_kind  = KIND_WORD;
      s_drop  = 2'd0;
      s_phase = phase_ff;
      s_tmode = tmode_ff;
      s_note  = note_ff;
      s_tl    = tok_left_ff;
      s_tf    = tok_first_ff;
      s_tk    = tok_kind_ff;
      case (phase_ff)
         PH_BETWEEN: begin
            s_drop = 2'd1;
            if (c0[7]) begin
               if (c0[6] && !note_ff) begin
                  s_emit = 1'b1;
                  s_ev   = EV_NONASCII;
                  s_note = 1'b1;
               end
            end else begin
               s_note = 1'b0;
               if (is_space(c0)) begin
                  s_inc = (c0 == 8'h0a);
               end else if (c0 == "#") begin
                  s_phase = PH_LINE_CMT;
               end else begin
                  s_drop  = 2'd0;
                  s_phase = PH_START;
                  s_tmode = mode_ff;
               end
            end
         end
         PH_LINE_CMT: begin
            s_drop = 2'd1;
            if (c0 == 8'h0a) begin
               s_inc   = 1'b1;
               s_phase = PH_BETWEEN;
            end
         end
         PH_BLOCK, PH_BLOCK_STAR: begin
            s_drop = 2'd1;
            s_inc  = (c0 == 8'h0a);
            if (phase_ff == PH_BLOCK_STAR && c0 == "/") s_phase = PH_BETWEEN;
            else s_phase = (c0 == "*") ? PH_BLOCK_STAR : PH_BLOCK;
         end
         PH_QUOTE: begin
            s_emit = 1'b1;
            s_byte = c0;
            s_last = (c0 == "\"");
            s_kind = KIND_QUOTED;
            s_drop = 2'd1;
            if (c0 == "\"") s_phase = PH_BETWEEN;
         end
         PH_WORD_FIRST, PH_WORD: begin
            if (!have1 && !end_ff) begin
               s_wait = 1'b1;
            end else begin
               s_emit  = 1'b1;
               s_byte  = c0;
               s_first = (phase_ff == PH_WORD_FIRST);
               s_last  = !have1 || !in_class(c1, tmode_ff);
               s_kind  = KIND_WORD;
               s_drop  = 2'd1;
               s_phase = s_last ? PH_BETWEEN : PH_WORD;
            end
         end
         PH_EMIT: begin
            s_emit  = 1'b1;
            s_byte  = c0;
            s_first = tok_first_ff;
            s_last  = (tok_left_ff == 4'd1);
            s_kind  = tok_kind_ff;
            s_drop  = 2'd1;
            s_tl    = tok_left_ff - 4'd1;
            s_tf    = 1'b0;
            if (s_last) s_phase = PH_BETWEEN;
         end
         PH_START: begin
            s_phase = PH_EMIT;
            s_tf    = 1'b1;
            if (c0 == "\"") begin
               s_emit  = 1'b1;
               s_byte  = c0;
               s_first = 1'b1;
               s_kind  = KIND_QUOTED;
               s_drop  = 2'd1;
               s_phase = PH_QUOTE;
            end else if (!have1 && !end_ff && (in_wait_set(c0) || is_word_c0)) begin
               s_wait  = 1'b1;
               s_phase = PH_START;
            end else if (have1 && c0 == "/" && c1 == "*") begin
               s_drop  = 2'd2;
               s_phase = PH_BLOCK;
            end else if (have1 && c0 == "/" && c1 == "/") begin
               s_drop  = 2'd2;
               s_phase = PH_LINE_CMT;
            end else if (shl_pair && !have2 && !end_ff) begin
               s_wait  = 1'b1;
               s_phase = PH_START;
            end else if (shl_pair && have2 && c2 == "=") begin
               s_tl = 4'd3;
               s_tk = KIND_OPER;
            end else if (have1 && c1 == "=" && in_assign_ops(c0)) begin
               s_tl = 4'd2;
               s_tk = KIND_OPER;
            end else if (is_word_c0) begin
               s_phase = PH_WORD_FIRST;
            end else if (tmode_ff == MODE_EXPR && c0 == "/" && disc_ok &&
                         count_ff >= CNT_W'(DISCARD_LEN)) begin
               s_tl = 4'(DISCARD_LEN);
               s_tk = KIND_WORD;
            end else if (tmode_ff == MODE_EXPR && c0 == "/" && disc_ok && !end_ff) begin
               s_wait  = 1'b1;
               s_phase = PH_START;
            end else if (tmode_ff == MODE_EXPR && have1 &&
                         ((c1 == c0 && (c0 == "<" || c0 == ">" || c0 == "&" || c0 == "|")) ||
                          (c1 == "=" && (c0 == "=" || c0 == "!" || c0 == "<" ||
                                         c0 == ">")))) begin
               s_tl = 4'd2;
               s_tk = KIND_OPER;
            end else begin
               s_tl = 4'd1;
               s_tk = KIND_SINGLE;
            end
         end
         default: s_phase = PH_BETWEEN;
      endcase
   end

   assign status.halt     = (count_ff == '0) || s_wait;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.end_seen = end_ff;

   // state update
   always_comb begin
      for (int i = 0; i < LOOKAHEAD_DEPTH; i++) buf_in[i] = buf_ff[i];
      count_in     = count_ff;
      phase_in     = phase_ff;
      tmode_in     = tmode_ff;
      line_in      = line_ff;
      note_in      = note_ff;
      tok_left_in  = tok_left_ff;
      tok_first_in = tok_first_ff;
      tok_kind_in  = tok_kind_ff;
      end_in       = end_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ev_in        = ev_ff;
      byte_in      = byte_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      kind_in      = kind_ff;
      rline_in     = rline_ff;

      if (cmd.load) begin
         end_in  = req_end_of_text;
         mode_in = req_mode;
         if (count_ff < CNT_W'(LOOKAHEAD_DEPTH)) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
               if (CNT_W'(i) == count_ff) buf_in[i] = req_text_byte;
            end
            count_in = count_ff + CNT_W'(1);
         end
      end

      if (cmd.step) begin
         phase_in     = s_phase;
         tmode_in     = s_tmode;
         note_in      = s_note;
         tok_left_in  = s_tl;
         tok_first_in = s_tf;
         tok_kind_in  = s_tk;
         if (s_inc && line_ff != LINE_TOP) line_in = line_ff + LINE_ONE;
         if (s_drop == 2'd1) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) buf_in[i] = buf_ff[i+1];
         end else if (s_drop == 2'd2) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH - 2; i++) buf_in[i] = buf_ff[i+2];
         end
         count_in = count_ff - CNT_W'(s_drop);
         if (s_emit) begin
            rsp_valid_in = 1'b1;
            ev_in        = s_ev;
            byte_in      = s_byte;
            first_in     = s_first;
            last_in      = s_last;
            kind_in      = s_kind;
            rline_in     = line_ff;
         end
      end

      // unclosed quote or comment at end of text
      if (cmd.err && (phase_ff == PH_QUOTE || phase_ff == PH_BLOCK ||
                      phase_ff == PH_BLOCK_STAR)) begin
         rsp_valid_in = 1'b1;
         ev_in        = (phase_ff == PH_QUOTE) ? EV_OPEN_QT : EV_OPEN_CMT;
         byte_in      = 8'd0;
         first_in     = 1'b0;
         last_in      = 1'b0;
         kind_in      = KIND_WORD;
         rline_in     = line_ff;
      end

      // end of text, then back to the reset state
      if (cmd.eot) begin
         rsp_valid_in = 1'b1;
         ev_in        = EV_END;
         byte_in      = 8'd0;
         first_in     = 1'b0;
         last_in      = 1'b0;
         kind_in      = KIND_WORD;
         rline_in     = line_ff;
         count_in     = '0;
         phase_in     = PH_BETWEEN;
         tmode_in     = 2'd0;
         line_in      = LINE_ONE;
         note_in      = 1'b0;
         end_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= PH_BETWEEN;
         tmode_ff     <= 2'd0;
         line_ff      <= LINE_ONE;
         note_ff      <= 1'b0;
         tok_left_ff  <= 4'd0;
         tok_first_ff <= 1'b0;
         tok_kind_ff  <= KIND_WORD;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         tmode_ff     <= tmode_in;
         line_ff      <= line_in;
         note_ff      <= note_in;
         tok_left_ff  <= tok_left_in;
         tok_first_ff <= tok_first_in;
         tok_kind_ff  <= tok_kind_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < LOOKAHEAD_DEPTH; i++) buf_ff[i] <= buf_in[i];
      mode_ff  <= mode_in;
      ev_ff    <= ev_in;
      byte_ff  <= byte_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      kind_ff  <= kind_in;
      rline_ff <= rline_in;
   end

   assign line_ext        = {{LINE_OUT_W{1'b0}}, rline_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_token_byte  = byte_ff;
   assign rsp_token_first = first_ff;
   assign rsp_token_last  = last_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_line_number = line_ext[LINE_OUT_W-1:0];

   // buffer fill never passes its depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LOOKAHEAD_DEPTH))
      else $error("lookahead overflow");

   // a token in flight always has bytes left to send
   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EMIT) |-> (tok_left_ff != 4'd0 && count_ff >= CNT_W'(tok_left_ff)))
      else $error("token emission underflow");

   // the line counter never drops to zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line counter zero");

   // a new result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(cmd.step || cmd.err || cmd.eot))
      else $error("result slot overwritten");

endmodule

>>> src/linker_script_tokenizer.sv
// flow: a byte is taken in idle, then one scan step per cycle while the result slot
// is free, then control hands back to idle; a byte may pass a skip, a classify and a
// send step each time it is replayed from the buffer
// a new byte is taken only after the steps for the last one halt, and result stalls
// hold it back; end of text adds the closing events (open quote or comment, then end)
// reset: synchronous, active high; buffer empty, line counter 1; end of text also returns here
// ----------------------------------------------------------------------------
// linker_script_tokenizer
// Splits script bytes into tokens with kind, marks and line number.
// ----------------------------------------------------------------------------
module linker_script_tokenizer
   import ltok_pkg::*;
#(
   parameter int LOOKAHEAD_DEPTH = 9,
   parameter int LINE_BITS       = 24
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic [1:0]  req_mode,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_token_byte,
   output logic        rsp_token_first,
   output logic        rsp_token_last,
   output logic [1:0]  rsp_token_kind,
   output logic [23:0] rsp_line_number
);

   cmd_type    cmd;
   status_type status;

   ltok_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ltok_dp #(
      .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
      .LINE_BITS       (LINE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_text_byte   (req_text_byte),
      .req_mode        (req_mode),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_token_first (rsp_token_first),
      .rsp_token_last  (rsp_token_last),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_line_number (rsp_line_number)
   );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the script tokenizer: a directed table of short
// scripts, then random scripts built from well-formed fragments and noise,
// with each result checked against typed values or a predictor that runs beside the block.
// ----------------------------------------------------------------------------
module testbench
   import ltok_pkg::*;
();

   typedef struct packed {
      logic [2:0]  ev;
      logic [7:0]  tbyte;
      logic        first;
      logic        last;
      logic [1:0]  kind;
      logic [23:0] line;
   } token_res_type;

   typedef struct {
      logic [7:0] tbyte;
      logic [1:0] md;
      logic       eot;
      int         n_typed;   // -1: use the predictor
      token_res_type typed[3];
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic [1:0]  req_mode = 2'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_token_byte;
   logic        rsp_token_first;
   logic        rsp_token_last;
   logic [1:0]  rsp_token_kind;
   logic [23:0] rsp_line_number;

   linker_script_tokenizer u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_text_byte(req_text_byte), .req_mode(req_mode),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res), .rsp_token_byte(rsp_token_byte),
      .rsp_token_first(rsp_token_first), .rsp_token_last(rsp_token_last),
      .rsp_token_kind(rsp_token_kind), .rsp_line_number(rsp_line_number)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   logic [7:0]  la_buf[9];
   int          la_cnt;
   phase_type   scan_ph;
   logic [1:0]  tok_mode;
   logic [23:0] line_cnt;
   bit          note_done;
   token_res_type step_q[$];
   token_res_type expected_q[$];
   int          n_errors = 0;
   int          n_bytes = 0;
   int          n_results = 0;
   int          n_tokens = 0;

   function automatic bit word_char(logic [7:0] b, logic [1:0] m);
      string extra;
      if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9"))
         return 1'b1;
      if (m == MODE_EXPR) extra = "_.$";
      else if (m == MODE_SECTION && b == ":") return 1'b0;
      else extra = "_.$/\\~=+[]*?-!^:";
      for (int i = 0; i < extra.len(); i++)
         if (extra[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit char_of(string s, logic [7:0] b);
      for (int i = 0; i < s.len(); i++)
         if (s[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   task automatic tok_reset();
      la_cnt = 0;
      scan_ph = PH_BETWEEN;
      tok_mode = 2'd0;
      line_cnt = 24'd1;
      note_done = 1'b0;
   endtask

   task automatic give(logic [2:0] ev, logic [7:0] b, bit f, bit l, logic [1:0] k);
      token_res_type r;
      if (step_q.size() < 12) begin
         r = '{ev, b, f, l, k, line_cnt};
         step_q.insert(step_q.size(), r);
      end
   endtask

   task automatic shift_out(int k);
      if (k >= la_cnt) begin
         la_cnt = 0;
      end else begin
         for (int i = 0; i < la_cnt - k; i++) la_buf[i] = la_buf[i + k];
         la_cnt -= k;
      end
   endtask

   task automatic give_token(int len, logic [1:0] kind);
      for (int i = 0; i < len && i < la_cnt; i++)
         give(EV_TOKEN, la_buf[i], i == 0, i + 1 == len, kind);
      shift_out(len);
      scan_ph = PH_BETWEEN;
   endtask

   // decide the token at the buffer head; done=0 means more bytes are needed
   task automatic open_token(bit eot, output bit done);
      int n, c0, c1, c2, k;
      string discard;
      n = la_cnt;
      c0 = la_buf[0];
      c1 = -1;
      c2 = -1;
      discard = "/DISCARD/";
      done = 1'b1;
      if (c0 == "\"") begin
         give(EV_TOKEN, 8'(c0), 1, 0, KIND_QUOTED);
         shift_out(1);
         scan_ph = PH_QUOTE;
         return;
      end
      if (n < 2) begin
         if (!eot && (char_of("/<>+-*!&^|=", 8'(c0)) || word_char(8'(c0), tok_mode))) begin
            done = 1'b0;
            return;
         end
      end else c1 = la_buf[1];
      if (c0 == "/" && (c1 == "*" || c1 == "/")) begin
         scan_ph = (c1 == "*") ? PH_BLOCK : PH_LINE_CMT;
         shift_out(2);
         return;
      end
      if ((c0 == "<" || c0 == ">") && c1 == c0) begin
         if (n < 3) begin
            if (!eot) begin
               done = 1'b0;
               return;
            end
         end else c2 = la_buf[2];
         if (c2 == "=") begin
            give_token(3, KIND_OPER);
            return;
         end
      end
      if (c1 == "=" && char_of("+-*/!&^|", 8'(c0))) begin
         give_token(2, KIND_OPER);
         return;
      end
      if (word_char(8'(c0), tok_mode)) begin
         scan_ph = PH_WORD_FIRST;
         return;
      end
      if (tok_mode == MODE_EXPR) begin
         if (c0 == "/") begin
            for (k = 1; k < 9; k++) begin
               if (k >= n) begin
                  if (!eot) begin
                     done = 1'b0;
                     return;
                  end
                  break;
               end
               if (la_buf[k] != discard[k]) break;
            end
            if (k == 9) begin
               give_token(9, KIND_WORD);
               return;
            end
         end
         if (c1 >= 0 && ((c1 == c0 && char_of("<>&|", 8'(c0))) ||
                         (c1 == "=" && char_of("=!<>", 8'(c0))))) begin
            give_token(2, KIND_OPER);
            return;
         end
      end
      give_token(1, KIND_SINGLE);
   endtask

   task automatic settle_buf(bit eot, logic [1:0] md);
      logic [7:0] b;
      bit lst, done;
      forever begin
         if (la_cnt == 0) return;
         b = la_buf[0];
         case (scan_ph)
            PH_BETWEEN: begin
               if (b >= 8'h80) begin
                  if (b >= 8'hC0 && !note_done) begin
                     give(EV_NONASCII, 0, 0, 0, 0);
                     note_done = 1'b1;
                  end
                  shift_out(1);
               end else begin
                  note_done = 1'b0;
                  if (b inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d}) begin
                     if (b == 8'h0a && line_cnt != 24'hFFFFFF) line_cnt++;
                     shift_out(1);
                  end else if (b == "#") begin
                     shift_out(1);
                     scan_ph = PH_LINE_CMT;
                  end else begin
                     scan_ph = PH_START;
                     tok_mode = md;
                  end
               end
            end
            PH_LINE_CMT: begin
               shift_out(1);
               if (b == 8'h0a) begin
                  if (line_cnt != 24'hFFFFFF) line_cnt++;
                  scan_ph = PH_BETWEEN;
               end
            end
            PH_BLOCK, PH_BLOCK_STAR: begin
               shift_out(1);
               if (b == 8'h0a && line_cnt != 24'hFFFFFF) line_cnt++;
               if (scan_ph == PH_BLOCK_STAR && b == "/") scan_ph = PH_BETWEEN;
               else scan_ph = (b == "*") ? PH_BLOCK_STAR : PH_BLOCK;
            end
            PH_QUOTE: begin
               give(EV_TOKEN, b, 0, b == "\"", KIND_QUOTED);
               shift_out(1);
               if (b == "\"") scan_ph = PH_BETWEEN;
            end
            PH_WORD_FIRST, PH_WORD: begin
               if (la_cnt < 2 && !eot) return;
               lst = (la_cnt < 2) || !word_char(la_buf[1], tok_mode);
               give(EV_TOKEN, b, scan_ph == PH_WORD_FIRST, lst, KIND_WORD);
               shift_out(1);
               scan_ph = lst ? PH_BETWEEN : PH_WORD;
            end
            default: begin
               open_token(eot, done);
               if (!done) return;
            end
         endcase
      end
   endtask

   // results caused by one script byte, left in step_q
   task automatic tokenize_byte(logic [7:0] b, logic [1:0] md, bit eot);
      step_q.delete();
      if (la_cnt < 9) begin
         la_buf[la_cnt] = b;
         la_cnt++;
      end
      settle_buf(eot, md);
      if (eot) begin
         if (scan_ph == PH_QUOTE) give(EV_OPEN_QT, 0, 0, 0, 0);
         else if (scan_ph == PH_BLOCK || scan_ph == PH_BLOCK_STAR)
            give(EV_OPEN_CMT, 0, 0, 0, 0);
         give(EV_END, 0, 0, 0, 0);
         tok_reset();
      end
   endtask

   // ---------------------------------------------------------------- stimulus
   script_row_type rows[$];
   logic [7:0]  rnd_bytes[$];
   logic [1:0]  rnd_modes[$];
   bit          rnd_eots[$];
   bit          driving_done = 1'b0;
   int          idle_cycles = 0;

   function automatic token_res_type tr(logic [2:0] ev, logic [7:0] b, bit f, bit l,
                                        logic [1:0] k);
      return '{ev, b, f, l, k, 24'd1};
   endfunction

   task automatic add_row(logic [7:0] b, logic [1:0] md, bit eot, int nt = -1,
                          token_res_type r0 = '0, token_res_type r1 = '0,
                          token_res_type r2 = '0);
      script_row_type row;
      row.tbyte = b;
      row.md = md;
      row.eot = eot;
      row.n_typed = nt;
      row.typed[0] = r0;
      row.typed[1] = r1;
      row.typed[2] = r2;
      rows.insert(rows.size(), row);
   endtask

   task automatic add_text(string s, logic [1:0] md, bit eot_at_end);
      for (int i = 0; i < s.len(); i++)
         add_row(s[i], md, eot_at_end && i == s.len() - 1);
   endtask

   // one random fragment of script text
   task automatic add_fragment();
      string frags[18];
      string s;
      logic [1:0] md;
      frags = '{"/DISCARD/", "/DISC x", "<<=", ">>=", "+=", "&&", "==", "!=",
                "\"a b\nc\"", "/* c\n*x*/", "// n\n", "# n\n", "foo_1",
                ".text : ", "\n", " \t", "a<<b", "x=y;"};
      md = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
         0: begin
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
               rnd_bytes.insert(rnd_bytes.size(), 8'($urandom));
               rnd_modes.insert(rnd_modes.size(), 2'($urandom));
               rnd_eots.insert(rnd_eots.size(), 1'b0);
            end
            return;
         end
         1: s = string'({8'hC3, 8'hA9, 8'h80, 8'hF0, 8'h20});
         default: s = frags[$urandom_range(0, 17)];
      endcase
      for (int i = 0; i < s.len(); i++) begin
         rnd_bytes.insert(rnd_bytes.size(), s[i]);
         rnd_modes.insert(rnd_modes.size(), md);
         rnd_eots.insert(rnd_eots.size(), 1'b0);
      end
      if ($urandom_range(0, 11) == 0) rnd_eots[$] = 1'b1;
   endtask

   // drive one byte and hold it until the transfer
   task automatic send_byte(logic [7:0] b, logic [1:0] md, bit eot, int nt,
                            token_res_type typed[3]);
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_mode <= md;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tokenize_byte(b, md, eot);
      n_bytes++;
      if (nt < 0) begin
         foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
      end else begin
         for (int i = 0; i < nt; i++) expected_q.insert(expected_q.size(), typed[i]);
      end
   endtask

   initial begin
      int burst;
      token_res_type none[3];
      tok_reset();
      // directed scripts, typed where the outcome is plain
      add_row(";", 0, 1, 2, tr(EV_TOKEN, ";", 1, 1, KIND_SINGLE), tr(EV_END, 0, 0, 0, 0));
      add_row(8'hC3, 1, 1, 2, tr(EV_NONASCII, 0, 0, 0, 0), tr(EV_END, 0, 0, 0, 0));
      add_row("\"", 1, 1, 3, tr(EV_TOKEN, "\"", 1, 0, KIND_QUOTED),
              tr(EV_OPEN_QT, 0, 0, 0, 0), tr(EV_END, 0, 0, 0, 0));
      add_row("/", 0, 0);
      add_row("*", 0, 1, 2, tr(EV_OPEN_CMT, 0, 0, 0, 0), tr(EV_END, 0, 0, 0, 0));
      add_text("/DISCARD/ ", 0, 0);
      add_text("<<=a:b", 2, 0);
      add_text("\n", 3, 0);
      add_row(8'hFF, 1, 0);
      add_row(8'h00, 0, 0);
      add_text("|=", 0, 1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         send_byte(rows[i].tbyte, rows[i].md, rows[i].eot, rows[i].n_typed,
                   rows[i].typed);
      end
      // random scripts in bursts
      while (rnd_bytes.size() < 175) add_fragment();
      rnd_eots[$] = 1'b1;
      while (rnd_bytes.size() > 0) begin
         burst = $urandom_range(1, 10);
         while (burst > 0 && rnd_bytes.size() > 0) begin
            send_byte(rnd_bytes.pop_front(), rnd_modes.pop_front(),
                      rnd_eots.pop_front(), -1, none);
            burst--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      driving_done = 1'b1;
   end

   // receiver stall pattern: long ready runs, sparse stalls, heavy stalls
   int stall_cyc = 0;
   always @(posedge clock) begin
      stall_cyc <= stall_cyc + 1;
      case ((stall_cyc / 80) % 3)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 4) != 0);
         default: rsp_ready <= (stall_cyc % 7) < 2;
      endcase
   end

   // ---------------------------------------------------------------- checking
   token_res_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (expected_q.size() == 0) begin
            $error("result with nothing expected: event %0d", rsp_event_res);
            n_errors++;
         end else begin
            want = expected_q.pop_front();
            if (want.ev == EV_TOKEN && want.first) n_tokens++;
            if (rsp_event_res !== want.ev) begin
               $error("event_res expected %0d actual %0d", want.ev, rsp_event_res);
               n_errors++;
            end
            if (rsp_token_byte !== want.tbyte) begin
               $error("token_byte expected %0h actual %0h", want.tbyte, rsp_token_byte);
               n_errors++;
            end
            if (rsp_token_first !== want.first) begin
               $error("token_first expected %0d actual %0d", want.first, rsp_token_first);
               n_errors++;
            end
            if (rsp_token_last !== want.last) begin
               $error("token_last expected %0d actual %0d", want.last, rsp_token_last);
               n_errors++;
            end
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind expected %0d actual %0d", want.kind, rsp_token_kind);
               n_errors++;
            end
            if (rsp_line_number !== want.line) begin
               $error("line_number expected %0d actual %0d", want.line, rsp_line_number);
               n_errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("[linker_script_tokenizer] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- end of run
   initial begin
      wait (driving_done);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (expected_q.size() != 0) n_errors++;
      $display("bytes sent %0d, results checked %0d, tokens %0d, mismatches %0d",
               n_bytes, n_results, n_tokens, n_errors);
      if (n_errors == 0)
         $display("[linker_script_tokenizer] OK");
      else
         $display("[linker_script_tokenizer] ERROR");
      $finish;
   end

endmodule

>>> files.f
src/ltok_pkg.sv
src/ltok_ctrl.sv
src/ltok_dp.sv
src/linker_script_tokenizer.sv
dv/testbench.sv
